FILE: rtl/core/aes128_key_expansion_unit_defines.svh
// ----------------------------------------------------------------------------
// AES-128 key expansion unit: assertion macros
// Shared property macros for the checker of the key expansion unit.
// ----------------------------------------------------------------------------
`ifndef AES128_KEY_EXPANSION_UNIT_DEFINES_SVH
`define AES128_KEY_EXPANSION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define AESKE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aeske: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define AESKE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aeske: next-cycle check failed");

`endif

FILE: rtl/core/aeske_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 key expansion package
// Widths, step codes, microcode words and the S-box shared by the unit.
// ----------------------------------------------------------------------------
package aeske_pkg;

   localparam int WORD_W     = 32;
   localparam int KEY_HALF_W = 64;
   localparam int BLOCK_W    = 128;
   localparam int ADDR_W     = 6;
   localparam int WORDS      = 44;
   localparam int ROUNDS     = 10;
   localparam int ROWS       = WORDS / 4;
   localparam int ROW_W      = $clog2(ROWS);
   localparam int ROUND_W    = $clog2(ROUNDS + 1);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [2:0] {
      STEP_LOAD,
      STEP_SUB,
      STEP_XOR,
      STEP_FIN,
      STEP_RD,
      STEP_RDW
   } step_type;

   typedef enum logic [1:0] {
      JMP_GO,
      JMP_LOOP,
      JMP_STOP
   } jump_type;

   typedef struct packed {
      logic     key_wr;
      logic     sub_en;
      logic     xor_en;
      logic     rd_en;
      logic     emit;
      logic     emit_read;
      jump_type jump;
      step_type target;
      step_type fall;
   } ucode_type;

   typedef struct packed {
      logic               accept;
      logic               key_wr;
      logic               sub_en;
      logic               xor_en;
      logic               rd_en;
      logic               emit;
      logic               emit_read;
      logic [ROUND_W-1:0] round;
   } ctrl_type;

   // Microprogram: one control word per step.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type uc;
      uc = '{key_wr: 1'b0, sub_en: 1'b0, xor_en: 1'b0, rd_en: 1'b0, emit: 1'b0,
             emit_read: 1'b0, jump: JMP_STOP, target: STEP_LOAD, fall: STEP_LOAD};
      case (step)
         STEP_LOAD: begin
            uc.key_wr = 1'b1;
            uc.jump   = JMP_GO;
            uc.target = STEP_SUB;
         end
         STEP_SUB: begin
            uc.sub_en = 1'b1;
            uc.jump   = JMP_GO;
            uc.target = STEP_XOR;
         end
         STEP_XOR: begin
            uc.xor_en = 1'b1;
            uc.jump   = JMP_LOOP;
            uc.target = STEP_SUB;
            uc.fall   = STEP_FIN;
         end
         STEP_FIN: begin
            uc.emit = 1'b1;
            uc.jump = JMP_STOP;
         end
         STEP_RD: begin
            uc.rd_en  = 1'b1;
            uc.jump   = JMP_GO;
            uc.target = STEP_RDW;
         end
         STEP_RDW: begin
            uc.emit      = 1'b1;
            uc.emit_read = 1'b1;
            uc.jump      = JMP_STOP;
         end
         default: begin
            uc.jump = JMP_STOP;
         end
      endcase
      return uc;
   endfunction

   function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] round);
      logic [7:0] value;
      case (round)
         4'd0:    value = 8'h01;
         4'd1:    value = 8'h02;
         4'd2:    value = 8'h04;
         4'd3:    value = 8'h08;
         4'd4:    value = 8'h10;
         4'd5:    value = 8'h20;
         4'd6:    value = 8'h40;
         4'd7:    value = 8'h80;
         4'd8:    value = 8'h1b;
         4'd9:    value = 8'h36;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // SubWord(RotWord(w)) on a word whose first byte sits in the low bits.
   function automatic logic [WORD_W-1:0] sub_rot(input logic [WORD_W-1:0] w);
      return {SBOX[w[7:0]], SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]]};
   endfunction

endpackage

FILE: rtl/core/aeske_channels.sv
// ----------------------------------------------------------------------------
// AES-128 key expansion channels
// Valid/ready interfaces for the request and response channels.
// ----------------------------------------------------------------------------
interface aeske_req_if;
   import aeske_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  op;
   logic [KEY_HALF_W-1:0] key_low;
   logic [KEY_HALF_W-1:0] key_high;
   logic [ADDR_W-1:0]     read_addr;

   modport source (output valid, output op, output key_low, output key_high,
                   output read_addr, input ready);
   modport sink (input valid, input op, input key_low, input key_high,
                 input read_addr, output ready);
endinterface

interface aeske_rsp_if;
   import aeske_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word0;
   logic [WORD_W-1:0] word1;
   logic [WORD_W-1:0] word2;
   logic [WORD_W-1:0] word3;
   logic              done_res;

   modport source (output valid, output word0, output word1, output word2,
                   output word3, output done_res, input ready);
   modport sink (input valid, input word0, input word1, input word2,
                 input word3, input done_res, output ready);
endinterface

FILE: rtl/core/aeske_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module aeske_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 11
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: rtl/core/aeske_sequencer.sv
// ----------------------------------------------------------------------------
// AES-128 key expansion sequencer
// Step counter over the microprogram, with the round loop and request dispatch.
// ----------------------------------------------------------------------------
module aeske_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_op,
   input  logic               out_free,
   output logic               req_ready,
   output aeske_pkg::ctrl_type ctrl
);
   import aeske_pkg::*;

   logic               busy_ff;
   logic               busy_in;
   step_type           pc_ff;
   step_type           pc_in;
   logic [ROUND_W-1:0] round_ff;
   logic [ROUND_W-1:0] round_in;
   ucode_type          uc;
   logic               last_round;

   assign uc         = ucode_rom(pc_ff);
   assign last_round = (round_ff == ROUND_W'(ROUNDS - 1));

   always_comb begin
      busy_in  = busy_ff;
      pc_in    = pc_ff;
      round_in = round_ff;
      if (!busy_ff) begin
         if (req_valid) begin
            busy_in  = 1'b1;
            round_in = '0;
            pc_in    = (req_op == OP_READ) ? STEP_RD : STEP_LOAD;
         end
      end else begin
         case (uc.jump)
            JMP_GO: begin
               pc_in = uc.target;
            end
            JMP_LOOP: begin
               round_in = round_ff + ROUND_W'(1);
               pc_in    = last_round ? uc.fall : uc.target;
            end
            JMP_STOP: begin
               if (out_free) begin
                  busy_in = 1'b0;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      req_ready      = !busy_ff && !reset;
      ctrl.accept    = !busy_ff && !reset && req_valid;
      ctrl.key_wr    = busy_ff && uc.key_wr;
      ctrl.sub_en    = busy_ff && uc.sub_en;
      ctrl.xor_en    = busy_ff && uc.xor_en;
      ctrl.rd_en     = busy_ff && uc.rd_en;
      ctrl.emit      = busy_ff && uc.emit && out_free;
      ctrl.emit_read = uc.emit_read;
      ctrl.round     = round_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pc_ff    <= STEP_LOAD;
         round_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         pc_ff    <= pc_in;
         round_ff <= round_in;
      end
   end

endmodule

FILE: rtl/core/aeske_datapath.sv
// ----------------------------------------------------------------------------
// AES-128 key expansion datapath
// Key window, round function, round key store and the response register.
// ----------------------------------------------------------------------------
module aeske_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  aeske_pkg::ctrl_type             ctrl,
   input  logic [aeske_pkg::KEY_HALF_W-1:0] key_low,
   input  logic [aeske_pkg::KEY_HALF_W-1:0] key_high,
   input  logic [aeske_pkg::ADDR_W-1:0]     read_addr,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [aeske_pkg::WORD_W-1:0]     word0,
   output logic [aeske_pkg::WORD_W-1:0]     word1,
   output logic [aeske_pkg::WORD_W-1:0]     word2,
   output logic [aeske_pkg::WORD_W-1:0]     word3,
   output logic                            done_res
);
   import aeske_pkg::*;

   logic [BLOCK_W-1:0] win_ff;
   logic [WORD_W-1:0]  tmp_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [1:0]         off_ff;
   logic               expanded_ff;
   logic               rsp_valid_ff;
   logic [BLOCK_W-1:0] rsp_words_ff;
   logic               rsp_done_ff;

   logic [ADDR_W-1:0]  idx;
   logic [WORD_W-1:0]  n0, n1, n2, n3;
   logic [BLOCK_W-1:0] next_win;
   logic               ram_we;
   logic [ROW_W-1:0]   ram_wa;
   logic [BLOCK_W-1:0] ram_wd;
   logic [ROW_W-1:0]   row_next;
   logic [BLOCK_W-1:0] rd_a;
   logic [BLOCK_W-1:0] rd_b;
   logic [BLOCK_W-1:0] sel_words;

   assign idx = (read_addr >= ADDR_W'(WORDS)) ? read_addr - ADDR_W'(WORDS) : read_addr;

   assign n0       = win_ff[WORD_W-1:0] ^ tmp_ff;
   assign n1       = win_ff[2*WORD_W-1:WORD_W] ^ n0;
   assign n2       = win_ff[3*WORD_W-1:2*WORD_W] ^ n1;
   assign n3       = win_ff[4*WORD_W-1:3*WORD_W] ^ n2;
   assign next_win = {n3, n2, n1, n0};

   assign ram_we   = ctrl.key_wr || ctrl.xor_en;
   assign ram_wa   = ctrl.xor_en ? ROW_W'(ctrl.round + ROUND_W'(1)) : '0;
   assign ram_wd   = ctrl.xor_en ? next_win : win_ff;
   assign row_next = (row_ff == ROW_W'(ROWS - 1)) ? '0 : row_ff + ROW_W'(1);

   aeske_ram #(
      .WIDTH (BLOCK_W),
      .DEPTH (ROWS)
   ) u_store (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_wa),
      .wr_data   (ram_wd),
      .rd_en     (ctrl.rd_en),
      .rd_addr_a (row_ff),
      .rd_addr_b (row_next),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   always_comb begin
      case (off_ff)
         2'd0:    sel_words = rd_a;
         2'd1:    sel_words = {rd_b[WORD_W-1:0], rd_a[BLOCK_W-1:WORD_W]};
         2'd2:    sel_words = {rd_b[2*WORD_W-1:0], rd_a[BLOCK_W-1:2*WORD_W]};
         2'd3:    sel_words = {rd_b[3*WORD_W-1:0], rd_a[BLOCK_W-1:3*WORD_W]};
         default: sel_words = rd_a;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         win_ff <= {key_high, key_low};
         row_ff <= ROW_W'(idx >> 2);
         off_ff <= idx[1:0];
      end else if (ctrl.xor_en) begin
         win_ff <= next_win;
      end
      if (ctrl.sub_en) begin
         tmp_ff <= sub_rot(win_ff[BLOCK_W-1:3*WORD_W]) ^ {{(WORD_W-8){1'b0}}, rcon(ctrl.round)};
      end
      if (ctrl.emit) begin
         if (ctrl.emit_read) begin
            rsp_words_ff <= expanded_ff ? sel_words : '0;
            rsp_done_ff  <= expanded_ff;
         end else begin
            rsp_words_ff <= '0;
            rsp_done_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expanded_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.emit && !ctrl.emit_read) begin
            expanded_ff <= 1'b1;
         end
         if (ctrl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign word0     = rsp_words_ff[WORD_W-1:0];
   assign word1     = rsp_words_ff[2*WORD_W-1:WORD_W];
   assign word2     = rsp_words_ff[3*WORD_W-1:2*WORD_W];
   assign word3     = rsp_words_ff[4*WORD_W-1:3*WORD_W];
   assign done_res  = rsp_done_ff;

endmodule

FILE: rtl/core/aes128_key_expansion_unit.sv
// ----------------------------------------------------------------------------
// AES-128 key expansion unit
// Microcoded key schedule with an 11-row by 128-bit round key store.
//
//   Channel   Direction  Carries
//   req_bus   in         op, key_low, key_high, read_addr
//   rsp_bus   out        word0 to word3, done_res
//
// A load request runs these steps from acceptance to its response: a load step
// writes the key row, then ten rounds of two steps each (S-box, XOR chain and
// row write), then one finishing step. A read request runs a read step on the
// registered two-port read of the store, then an emit step. Reset is
// synchronous and empties the store logically. A response waiting on rsp_bus
// holds the final step of the next request, which is accepted meanwhile.
// ----------------------------------------------------------------------------
module aes128_key_expansion_unit (
   input logic        clock,
   input logic        reset,
   aeske_req_if.sink  req_bus,
   aeske_rsp_if.source rsp_bus
);
   import aeske_pkg::*;

   ctrl_type ctrl;
   logic     out_free;

   assign out_free = !rsp_bus.valid || rsp_bus.ready;

   aeske_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.op),
      .out_free  (out_free),
      .req_ready (req_bus.ready),
      .ctrl      (ctrl)
   );

   aeske_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .key_low   (req_bus.key_low),
      .key_high  (req_bus.key_high),
      .read_addr (req_bus.read_addr),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .word0     (rsp_bus.word0),
      .word1     (rsp_bus.word1),
      .word2     (rsp_bus.word2),
      .word3     (rsp_bus.word3),
      .done_res  (rsp_bus.done_res)
   );

endmodule

FILE: rtl/core/aeske_checker.sv
// ----------------------------------------------------------------------------
// AES-128 key expansion checker
// Port-level properties of the key expansion unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "aes128_key_expansion_unit_defines.svh"

module aeske_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_op,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [aeske_pkg::WORD_W-1:0] rsp_word0,
   input logic [aeske_pkg::WORD_W-1:0] rsp_word1,
   input logic [aeske_pkg::WORD_W-1:0] rsp_word2,
   input logic [aeske_pkg::WORD_W-1:0] rsp_word3,
   input logic                        rsp_done_res
);
   import aeske_pkg::*;

   `AESKE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_word0) && $stable(rsp_done_res))

   `AESKE_ASSERT_NEXT(a_read_busy, clock, reset,
      req_valid && req_ready && req_op == OP_READ, !req_ready)

   `AESKE_ASSERT_NEXT(a_load_busy, clock, reset,
      req_valid && req_ready && req_op == OP_LOAD, !req_ready ##1 !req_ready)

   `AESKE_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && !rsp_done_res,
      rsp_word0 == '0 && rsp_word1 == '0 && rsp_word2 == '0 && rsp_word3 == '0)

endmodule

bind aes128_key_expansion_unit aeske_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .req_op       (req_bus.op),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_word0    (rsp_bus.word0),
   .rsp_word1    (rsp_bus.word1),
   .rsp_word2    (rsp_bus.word2),
   .rsp_word3    (rsp_bus.word3),
   .rsp_done_res (rsp_bus.done_res)
);
